>>> rtl/core/acbc_pkg.sv
// Shared types, constants and S-box tables for the AES-CBC block cipher.
`timescale 1ns / 1ps
package acbc_pkg;

  localparam int unsigned KeyRows  = 15;
  localparam int unsigned RowAw    = 4;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD3 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_MODE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_IV_HIGH   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_IV_LOW    = 3'd6;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  typedef enum logic [1:0] {
    OP_ENC_KEY,
    OP_ENC_ROUND,
    OP_DEC_ROUND,
    OP_DEC_LAST
  } op_e;

  typedef struct packed {
    logic load;
    logic run;
    op_e  op;
    logic mix;
    logic last;
    logic out_load;
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RSBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [3:0] num_rounds(input logic [1:0] mode);
    logic [3:0] nr;
    case (mode)
      MODE_128: nr = 4'd10;
      MODE_192: nr = 4'd12;
      default:  nr = 4'd14;
    endcase
    return nr;
  endfunction

endpackage

>>> rtl/core/acbc_key_sched.sv
// Round key expansion, one key word per cycle, into the round key memory.
`timescale 1ns / 1ps
module acbc_key_sched (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic [255:0]                key_i,
  input  logic [1:0]                  mode_i,
  input  logic [acbc_pkg::RowAw-1:0]  rd_addr_i,
  output logic [127:0]                rk_o,
  output logic                        busy_o
);

  logic         busy_q;
  logic [5:0]   idx_q;
  logic [2:0]   m_q;
  logic [7:0]   rcon_q;
  logic [31:0]  win_q [8];
  logic [127:0] mem_q [acbc_pkg::KeyRows];
  logic [127:0] rk_q;

  logic [3:0]  nr;
  logic [2:0]  nk_m1;
  logic [5:0]  last_idx;
  logic [31:0] old_w;
  logic [31:0] t_rot;
  logic [31:0] t;
  logic [31:0] nw;
  logic        in_key;

  assign nr       = acbc_pkg::num_rounds(mode_i);
  assign nk_m1    = 3'(nr - 4'd7);
  assign last_idx = 6'({nr, 2'b00} + 6'd3);
  assign in_key   = idx_q <= {3'b000, nk_m1};
  assign t_rot    = {win_q[0][23:0], win_q[0][31:24]};

  always_comb begin
    old_w = win_q[nk_m1];
    t     = win_q[0];
    if (m_q == 3'd0) begin
      t = {acbc_pkg::SBOX[t_rot[31:24]] ^ rcon_q, acbc_pkg::SBOX[t_rot[23:16]],
           acbc_pkg::SBOX[t_rot[15:8]], acbc_pkg::SBOX[t_rot[7:0]]};
    end else if (nk_m1 == 3'd7 && m_q == 3'd4) begin
      t = {acbc_pkg::SBOX[win_q[0][31:24]], acbc_pkg::SBOX[win_q[0][23:16]],
           acbc_pkg::SBOX[win_q[0][15:8]], acbc_pkg::SBOX[win_q[0][7:0]]};
    end
    if (in_key) begin
      nw = key_i[255 - 32*idx_q[2:0] -: 32];
    end else begin
      nw = old_w ^ t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      m_q    <= '0;
      rcon_q <= 8'h01;
    end else if (restart_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      m_q    <= '0;
      rcon_q <= 8'h01;
    end else if (busy_q) begin
      idx_q <= idx_q + 6'd1;
      m_q   <= (m_q == nk_m1) ? 3'd0 : m_q + 3'd1;
      if (!in_key && m_q == 3'd0) begin
        rcon_q <= acbc_pkg::xtime(rcon_q);
      end
      if (idx_q == last_idx) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !restart_i) begin
      win_q[0] <= nw;
      for (int j = 1; j < 8; j++) begin
        win_q[j] <= win_q[j-1];
      end
      if (idx_q[1:0] == 2'd3) begin
        mem_q[idx_q[5:2]] <= {win_q[2], win_q[1], win_q[0], nw};
      end
    end
    rk_q <= mem_q[rd_addr_i];
  end

  assign rk_o   = rk_q;
  assign busy_o = busy_q;

endmodule

>>> rtl/core/acbc_datapath.sv
// Block state, chaining registers, round logic and output register.
`timescale 1ns / 1ps
module acbc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acbc_pkg::dp_cmd_t    cmd_i,
  input  logic                 func_i,
  input  logic                 chain_start_i,
  input  logic [127:0]         din_i,
  input  logic [127:0]         iv_i,
  input  logic [127:0]         rk_i,
  output logic [127:0]         dout_o
);

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      o[8*i +: 8] = inv ? acbc_pkg::RSBOX[s[8*i +: 8]] : acbc_pkg::SBOX[s[8*i +: 8]];
    end
    return o;
  endfunction

  // byte i sits at bits [127-8i -: 8]
  function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = s;
    for (int r = 1; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          o[127 - 8*(r + 4*((c + r) % 4)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
        end else begin
          o[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + r) % 4)) -: 8];
        end
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = s[127 - 8*(4*c + k) -: 8];
        x2[k] = acbc_pkg::xtime(a[k]);
        x4[k] = acbc_pkg::xtime(x2[k]);
        x8[k] = acbc_pkg::xtime(x4[k]);
        m9[k] = x8[k] ^ a[k];
        mb[k] = x8[k] ^ x2[k] ^ a[k];
        md[k] = x8[k] ^ x4[k] ^ a[k];
        me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      for (int k = 0; k < 4; k++) begin
        if (inv) begin
          o[127 - 8*(4*c + k) -: 8] = me[k] ^ mb[(k+1)%4] ^ md[(k+2)%4] ^ m9[(k+3)%4];
        end else begin
          o[127 - 8*(4*c + k) -: 8] = x2[k] ^ x2[(k+1)%4] ^ a[(k+1)%4] ^ a[(k+2)%4]
                                      ^ a[(k+3)%4];
        end
      end
    end
    return o;
  endfunction

  logic [127:0] state_q, state_d;
  logic [127:0] xor_q;
  logic [127:0] din_q;
  logic [127:0] chain_q;
  logic [127:0] out_q;
  logic [127:0] cv;
  logic [127:0] enc_t;
  logic [127:0] dec_t;

  assign cv = chain_start_i ? iv_i : chain_q;

  always_comb begin
    enc_t = row_shift(sub_bytes(state_q, 1'b0), 1'b0);
    if (cmd_i.mix) begin
      enc_t = mix_cols(enc_t, 1'b0);
    end
    dec_t = state_q ^ rk_i;
    if (cmd_i.mix) begin
      dec_t = mix_cols(dec_t, 1'b1);
    end
    dec_t = sub_bytes(row_shift(dec_t, 1'b1), 1'b1);
    case (cmd_i.op)
      acbc_pkg::OP_ENC_KEY:   state_d = state_q ^ rk_i;
      acbc_pkg::OP_ENC_ROUND: state_d = enc_t ^ rk_i;
      acbc_pkg::OP_DEC_ROUND: state_d = dec_t;
      acbc_pkg::OP_DEC_LAST:  state_d = state_q ^ rk_i ^ xor_q;
      default:                state_d = state_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      state_q <= func_i ? din_i : din_i ^ cv;
      xor_q   <= cv;
      din_q   <= din_i;
    end else if (cmd_i.run) begin
      state_q <= state_d;
    end
    if (cmd_i.out_load) begin
      out_q <= state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else if (cmd_i.run && cmd_i.last) begin
      chain_q <= (cmd_i.op == acbc_pkg::OP_DEC_LAST) ? din_q : state_d;
    end
  end

  assign dout_o = out_q;

endmodule

>>> rtl/core/acbc_ctrl.sv
// Round sequencer and output handshake control.
`timescale 1ns / 1ps
module acbc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic                        key_busy_i,
  input  logic [1:0]                  mode_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [acbc_pkg::RowAw-1:0]  rd_addr_o,
  output acbc_pkg::dp_cmd_t           cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       dec_q, dec_d;
  logic       oval_q, oval_d;
  logic [3:0] nr;
  logic       accept;
  logic       at_end;

  function automatic logic [3:0] key_row(input logic [3:0] step, input logic dec,
                                         input logic [3:0] nrr);
    logic [3:0] row;
    if (!dec) begin
      row = step;
    end else if (step < nrr) begin
      row = nrr - step;
    end else begin
      row = 4'd0;
    end
    return row;
  endfunction

  assign nr         = acbc_pkg::num_rounds(mode_i);
  assign in_ready_o = (state_q == ST_IDLE) && !key_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign at_end     = step_q == nr;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    dec_d     = dec_q;
    oval_d    = oval_q && !out_ready_i;
    cmd_o     = '0;
    cmd_o.op  = dec_q ? acbc_pkg::OP_DEC_ROUND : acbc_pkg::OP_ENC_ROUND;
    rd_addr_o = key_row(4'd0, func_i, nr);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          step_d     = 4'd0;
          dec_d      = func_i;
        end
      end
      ST_RUN: begin
        cmd_o.run  = 1'b1;
        cmd_o.last = at_end;
        rd_addr_o  = at_end ? 4'd0 : key_row(step_q + 4'd1, dec_q, nr);
        if (dec_q) begin
          cmd_o.op  = at_end ? acbc_pkg::OP_DEC_LAST : acbc_pkg::OP_DEC_ROUND;
          cmd_o.mix = step_q != 4'd0;
        end else begin
          cmd_o.op  = (step_q == 4'd0) ? acbc_pkg::OP_ENC_KEY : acbc_pkg::OP_ENC_ROUND;
          cmd_o.mix = !at_end;
        end
        if (at_end) begin
          state_d = ST_HOLD;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_HOLD: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          oval_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      dec_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      dec_q   <= dec_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o = oval_q;

endmodule

>>> rtl/core/aes_cbc_block_cipher.sv
// AES-CBC block cipher top level: configuration registers and unit wiring.
`timescale 1ns / 1ps
// One 128-bit block is processed per transfer, one AES round per clock. An
// item passes through its accept cycle, its rounds on the shared round unit
// and the load of the output register, which waits while a result is still
// untaken; the next input transfer can only follow after that. The output
// register lets the next block enter while a result waits. After reset and
// after every write to a key word or the key length, the key schedule
// refills the round key memory, one word per cycle, and s_axis_tready stays
// low until it is done.
module aes_cbc_block_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [acbc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [127:0]                  s_axis_tdata,  // data_high, data_low
  input  logic [1:0]                    s_axis_tuser,  // func, chain_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [127:0]                  m_axis_tdata   // result_high, result_low
);

  logic [63:0] key0_q, key1_q, key2_q, key3_q, iv_hi_q, iv_lo_q;
  logic [1:0]  mode_q;
  logic        cfg_wr;
  logic        key_wr;
  logic        key_busy;
  logic [acbc_pkg::RowAw-1:0] rd_addr;
  logic [127:0] rk;
  logic [127:0] dout;
  acbc_pkg::dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign key_wr      = cfg_wr && (cfg_index_i == acbc_pkg::REG_KEY_WORD0 ||
                                  cfg_index_i == acbc_pkg::REG_KEY_WORD1 ||
                                  cfg_index_i == acbc_pkg::REG_KEY_WORD2 ||
                                  cfg_index_i == acbc_pkg::REG_KEY_WORD3 ||
                                  cfg_index_i == acbc_pkg::REG_KEY_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      mode_q  <= '0;
      iv_hi_q <= '0;
      iv_lo_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        acbc_pkg::REG_KEY_WORD0: key0_q  <= cfg_data_i;
        acbc_pkg::REG_KEY_WORD1: key1_q  <= cfg_data_i;
        acbc_pkg::REG_KEY_WORD2: key2_q  <= cfg_data_i;
        acbc_pkg::REG_KEY_WORD3: key3_q  <= cfg_data_i;
        acbc_pkg::REG_KEY_MODE:  mode_q  <= cfg_data_i[1:0];
        acbc_pkg::REG_IV_HIGH:   iv_hi_q <= cfg_data_i;
        acbc_pkg::REG_IV_LOW:    iv_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  acbc_key_sched u_key_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (key_wr),
    .key_i     ({key0_q, key1_q, key2_q, key3_q}),
    .mode_i    (mode_q),
    .rd_addr_i (rd_addr),
    .rk_o      (rk),
    .busy_o    (key_busy)
  );

  acbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (s_axis_tuser[0]),
    .key_busy_i  (key_busy),
    .mode_i      (mode_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rd_addr_o   (rd_addr),
    .cmd_o       (cmd)
  );

  acbc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (s_axis_tuser[0]),
    .chain_start_i (s_axis_tuser[1]),
    .din_i         ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .iv_i          ({iv_hi_q, iv_lo_q}),
    .rk_i          (rk),
    .dout_o        (dout)
  );

  assign m_axis_tdata = {dout[63:0], dout[127:64]};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  a_key_write_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr |=> !s_axis_tready)
    else $error("input ready during key expansion");

  a_no_run_while_expanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_busy |-> !cmd.load)
    else $error("block loaded while round keys incomplete");

endmodule

>>> tb/sv/aes_cbc_block_cipher_test.sv
// Self-checking testbench for the AES-CBC block cipher: key sizes, chaining and flow control.
`timescale 1ns / 1ps
module aes_cbc_block_cipher_test;

  localparam logic [acbc_pkg::CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] MODE_256  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam bit FUNC_ENC = 1'b0;
  localparam bit FUNC_DEC = 1'b1;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [acbc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  aes_cbc_block_cipher i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // cipher shadow state
  logic [63:0] key_reg [4];
  logic [1:0] key_mode;
  logic [63:0] iv_hi, iv_lo;
  logic [63:0] chain_hi, chain_lo;
  logic [127:0] rkey [15];
  int round_total;
  block_t expected_blocks [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 0;
  logic stall_hold = 1'b0;
  int errors = 0;
  int blocks_sent = 0;
  int blocks_checked = 0;
  int cfg_writes = 0;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] x);
    return {acbc_pkg::SBOX[x[31:24]], acbc_pkg::SBOX[x[23:16]],
            acbc_pkg::SBOX[x[15:8]], acbc_pkg::SBOX[x[7:0]]};
  endfunction

  function void expand_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0] rc;
    int nk, total;
    round_total = (key_mode == acbc_pkg::MODE_128) ? 10 :
                  (key_mode == acbc_pkg::MODE_192) ? 12 : 14;
    nk = round_total - 6;
    total = 4 * (round_total + 1);
    for (int i = 0; i < nk; i++)
      w[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
    rc = 8'h01;
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_word(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r <= round_total; r++)
      rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] round_fn(logic [127:0] v, bit inv, bit mix);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
    if (!inv) begin
      for (int i = 0; i < 16; i++) t[i] = acbc_pkg::SBOX[s[i]];
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) s[r+4*c] = t[r+4*((c+r)&3)];
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
        if (inv) begin
          s[4*c]   = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
          s[4*c+1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
          s[4*c+2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
          s[4*c+3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
        end else begin
          s[4*c]   = gmul(a0, 8'd2) ^ gmul(a1, 8'd3) ^ a2 ^ a3;
          s[4*c+1] = a0 ^ gmul(a1, 8'd2) ^ gmul(a2, 8'd3) ^ a3;
          s[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'd2) ^ gmul(a3, 8'd3);
          s[4*c+3] = gmul(a0, 8'd3) ^ a1 ^ a2 ^ gmul(a3, 8'd2);
        end
      end
    end
    if (inv) begin
      for (int i = 0; i < 16; i++) t[i] = s[i];
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) s[r+4*((c+r)&3)] = acbc_pkg::RSBOX[t[r+4*c]];
    end
    for (int i = 0; i < 16; i++) v[127-8*i -: 8] = s[i];
    return v;
  endfunction

  function void predict_block(bit func, bit start, logic [63:0] hi, logic [63:0] lo);
    logic [127:0] chain, v;
    block_t b;
    chain = start ? {iv_hi, iv_lo} : {chain_hi, chain_lo};
    if (func == FUNC_ENC) begin
      v = {hi, lo} ^ chain ^ rkey[0];
      for (int r = 1; r <= round_total; r++) v = round_fn(v, 1'b0, r < round_total) ^ rkey[r];
      {chain_hi, chain_lo} = v;
    end else begin
      v = {hi, lo};
      for (int r = round_total; r >= 1; r--) v = round_fn(v ^ rkey[r], 1'b1, r < round_total);
      v = v ^ rkey[0] ^ chain;
      {chain_hi, chain_lo} = {hi, lo};
    end
    b.hi = v[127:64];
    b.lo = v[63:0];
    expected_blocks.push_back(b);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // result side
  always begin
    @(posedge clk_i);
    if (hold_go) begin
      hold_go = 0;
      stall_hold <= 1'b1;
      repeat (400) @(posedge clk_i);
      stall_hold <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    block_t want;
    m_axis_tready <= !stall_hold && ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata[63:0], 64'h0);
      end else begin
        want = expected_blocks.pop_front();
        if (m_axis_tdata[63:0] !== want.hi)
          report_mismatch("result_high", m_axis_tdata[63:0], want.hi);
        if (m_axis_tdata[127:64] !== want.lo)
          report_mismatch("result_low", m_axis_tdata[127:64], want.lo);
        blocks_checked++;
      end
    end
  end

  task automatic write_reg(logic [acbc_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
    case (idx)
      acbc_pkg::REG_KEY_WORD0, acbc_pkg::REG_KEY_WORD1,
      acbc_pkg::REG_KEY_WORD2, acbc_pkg::REG_KEY_WORD3: begin
        key_reg[idx[1:0]] = value;
        expand_keys();
      end
      acbc_pkg::REG_KEY_MODE: begin
        key_mode = value[1:0];
        expand_keys();
      end
      acbc_pkg::REG_IV_HIGH: iv_hi = value;
      acbc_pkg::REG_IV_LOW: iv_lo = value;
      default: ;
    endcase
  endtask

  task automatic send_block(bit func, bit start, logic [63:0] hi, logic [63:0] lo);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {lo, hi};
    s_axis_tuser <= {start, func};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_block(func, start, hi, lo);
    blocks_sent++;
  endtask

  task automatic drain();
    int guard;
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (expected_blocks.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (30) @(posedge clk_i);
  endtask

  task automatic load_key(logic [1:0] mode, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    write_reg(acbc_pkg::REG_KEY_WORD0, k0);
    write_reg(acbc_pkg::REG_KEY_WORD1, k1);
    write_reg(acbc_pkg::REG_KEY_WORD2, k2);
    write_reg(acbc_pkg::REG_KEY_WORD3, k3);
    write_reg(acbc_pkg::REG_KEY_MODE, {62'h0, mode});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_chaining();
    send_block(FUNC_ENC, 1'b0, 64'h0, 64'h0);
    send_block(FUNC_ENC, 1'b0, '1, '1);
    send_block(FUNC_DEC, 1'b1, '1, 64'h0);
    send_block(FUNC_DEC, 1'b0, 64'h0, '1);
    drain();
  endtask

  task automatic test_key_sizes();
    load_key(acbc_pkg::MODE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    write_reg(acbc_pkg::REG_IV_HIGH, 64'h0);
    write_reg(acbc_pkg::REG_IV_LOW, 64'h0);
    write_reg(REG_UNUSED, '1);
    send_block(FUNC_ENC, 1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(FUNC_DEC, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    drain();
    load_key(acbc_pkg::MODE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '1);
    write_reg(acbc_pkg::REG_IV_HIGH, '1);
    write_reg(acbc_pkg::REG_IV_LOW, 64'h0123456789abcdef);
    send_block(FUNC_ENC, 1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(FUNC_ENC, 1'b0, '1, '1);
    send_block(FUNC_DEC, 1'b1, 64'h0, 64'h0);
    drain();
    load_key(MODE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(FUNC_ENC, 1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(FUNC_DEC, 1'b0, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    drain();
    load_key(MODE_RSVD, '1, '1, '1, '1);
    send_block(FUNC_ENC, 1'b1, '1, '1);
    send_block(FUNC_DEC, 1'b0, 64'h0, 64'h0);
    drain();
  endtask

  task automatic test_random_streams(int idle_pct, int stall_pct, int count);
    bit func;
    int run;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
    write_reg(acbc_pkg::REG_IV_HIGH, rand64());
    write_reg(acbc_pkg::REG_IV_LOW, rand64());
    while (count > 0) begin
      func = 1'($urandom_range(1));
      run = $urandom_range(8, 1);
      for (int i = 0; i < run && count > 0; i++, count--) begin
        if ($urandom_range(9) < 2)
          send_block(1'($urandom_range(1)), 1'($urandom_range(1)), rand64(), rand64());
        else
          send_block(func, (i == 0) && ($urandom_range(9) < 8), rand64(), rand64());
      end
    end
    drain();
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1;
    for (int i = 0; i < 30; i++)
      send_block(1'($urandom_range(1)), i == 0, rand64(), rand64());
    drain();
  endtask

  initial begin
    key_reg = '{default: 64'h0};
    key_mode = acbc_pkg::MODE_128;
    iv_hi = 64'h0;
    iv_lo = 64'h0;
    chain_hi = 64'h0;
    chain_lo = 64'h0;
    expand_keys();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_chaining();
    test_key_sizes();
    test_random_streams(0, 0, 200);
    test_random_streams(85, 0, 200);
    test_random_streams(0, 85, 200);
    test_random_streams(13, 13, 200);
    test_output_hold();
    $display("covered %0d blocks in all key sizes, both directions, %0d register writes",
             blocks_sent, cfg_writes);
    $display("%0d results checked, %0d left unanswered", blocks_checked,
             expected_blocks.size());
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
